@@ rtl/fnas_pkg.sv @@
// Shared constants and types of the four-neighbour average stencil.
`timescale 1ns / 1ps

package fnas_pkg;

    localparam int DATA_W       = 16;
    localparam int SIZE_W       = 11;
    localparam int MAX_SIZE_DEF = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd4;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] prev_cur;
        logic signed [DATA_W-1:0] prev_nxt;
        logic signed [DATA_W-1:0] pprev_cur;
    } t_row_rd;

    typedef struct packed {
        logic signed [DATA_W-1:0] prev;
        logic signed [DATA_W-1:0] pprev;
    } t_row_wd;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_res;

endpackage

@@ rtl/four_neighbour_average_stencil.sv @@
// Top level of the four-neighbour average stencil over a square raster matrix.
//
//   Channel   Direction  Payload                          Beat when
//   s_axis    in         tdata[15:0] sample               tvalid && tready
//   m_axis    out        tdata[15:0] value, tlast last    tvalid && tready
//   APB       in/out     matrix_size at byte address 0    psel && penable && pwrite
//
// One input beat per cycle while tready is high; a beat on the last row gives two results,
// so there the output port sets the pace.
// A result passes the registered row memory read and the result queue before it leaves.
// The previous-row memory serves two reads and one write every cycle.
// Reset clears the position counters, the pipeline and the result queue; row memories
// are not cleared. tready falls when the queue cannot take two more results.
`timescale 1ns / 1ps

module four_neighbour_average_stencil #(
    parameter int MAX_SIZE = fnas_pkg::MAX_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] value
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fnas_pkg::PADDR_W-1:0]  paddr,
    input  logic [fnas_pkg::APB_DW-1:0]   pwdata,
    output logic [fnas_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int CW = (NW > fnas_pkg::SIZE_W) ? NW : fnas_pkg::SIZE_W;
    localparam int QW = fnas_pkg::OUT_CNT_W + 1;

    logic [fnas_pkg::SIZE_W-1:0] r_matrix_size;
    logic [AW-1:0]               r_row;
    logic [AW-1:0]               r_col;
    logic [AW-1:0]               last_idx;
    logic [CW-1:0]               size_ext;
    logic                        cfg_wr;
    logic                        in_acc;

    logic                               r_b_valid;
    logic signed [fnas_pkg::DATA_W-1:0] r_b_sample;
    logic [AW-1:0]                      r_b_col;
    logic                               r_b_has_up;
    logic                               r_b_interior;
    logic                               r_b_self;
    logic                               r_b_last;
    logic signed [fnas_pkg::DATA_W-1:0] r_left;

    fnas_pkg::t_row_rd rd_data;
    fnas_pkg::t_row_wd wr_data;
    fnas_pkg::t_res    res_a;
    fnas_pkg::t_res    res_b;
    fnas_pkg::t_res    head;

    logic signed [fnas_pkg::DATA_W+1:0] sum;
    logic [fnas_pkg::OUT_CNT_W-1:0]     q_count;
    logic [QW-1:0]                      q_need;
    logic                               pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fnas_pkg::REG_MATRIX_SIZE);
    assign prdata = (paddr[2] == fnas_pkg::REG_MATRIX_SIZE)
                    ? fnas_pkg::APB_DW'(r_matrix_size) : '0;

    always_comb begin
        size_ext = CW'(r_matrix_size);
        if (size_ext == '0) begin
            last_idx = '0;
        end else if (size_ext > CW'(MAX_SIZE)) begin
            last_idx = AW'(MAX_SIZE - 1);
        end else begin
            last_idx = AW'(size_ext - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= fnas_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            r_matrix_size <= pwdata[fnas_pkg::SIZE_W-1:0];
        end
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if (r_col == last_idx) begin
                r_col <= '0;
                r_row <= (r_row == last_idx) ? '0 : r_row + AW'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_sample   <= s_axis_tdata;
            r_b_col      <= r_col;
            r_b_has_up   <= (r_row != '0);
            r_b_interior <= (r_row > AW'(1)) && (r_col != '0) && (r_col != last_idx);
            r_b_self     <= (r_row == last_idx);
            r_b_last     <= (r_col == last_idx);
        end
        if (r_b_valid) begin
            r_left <= rd_data.prev_cur;
        end
    end

    assign wr_data.prev  = r_b_sample;
    assign wr_data.pprev = rd_data.prev_cur;

    fnas_row_store #(
        .MAX_SIZE (MAX_SIZE)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_col),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_comb begin
        sum = {{2{rd_data.pprev_cur[15]}}, rd_data.pprev_cur}
            + {{2{r_b_sample[15]}}, r_b_sample}
            + {{2{r_left[15]}}, r_left}
            + {{2{rd_data.prev_nxt[15]}}, rd_data.prev_nxt};
        res_a.value = r_b_interior ? sum[fnas_pkg::DATA_W+1:2] : rd_data.prev_cur;
        res_a.last  = 1'b0;
        res_b.value = r_b_sample;
        res_b.last  = r_b_last;
    end

    assign pop = m_axis_tvalid && m_axis_tready;

    fnas_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (r_b_valid && r_b_has_up),
        .i_res_a  (res_a),
        .i_push_b (r_b_valid && r_b_self),
        .i_res_b  (res_b),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (q_count)
    );

    assign q_need = QW'(q_count) + (r_b_valid ? QW'(2) : QW'(0)) + QW'(2);
    assign s_axis_tready = (q_need <= QW'(fnas_pkg::OUT_DEPTH));

    assign m_axis_tvalid = (q_count != '0);
    assign m_axis_tdata  = head.value;
    assign m_axis_tlast  = head.last;

endmodule

@@ rtl/fnas_row_store.sv @@
// Two row memories with registered reads and write-to-read forwarding.
`timescale 1ns / 1ps

module fnas_row_store #(
    parameter int MAX_SIZE = fnas_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_SIZE)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(MAX_SIZE)-1:0] i_wr_addr,
    input  fnas_pkg::t_row_wd           i_wr_data,
    output fnas_pkg::t_row_rd           o_rd_data
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SIZE - 1);

    logic signed [fnas_pkg::DATA_W-1:0] r_mem_prev  [MAX_SIZE];
    logic signed [fnas_pkg::DATA_W-1:0] r_mem_pprev [MAX_SIZE];

    logic [AW-1:0] nxt_addr;
    logic          fwd_cur;
    logic          fwd_nxt;

    logic signed [fnas_pkg::DATA_W-1:0] r_raw_prev_cur;
    logic signed [fnas_pkg::DATA_W-1:0] r_raw_prev_nxt;
    logic signed [fnas_pkg::DATA_W-1:0] r_raw_pprev_cur;
    logic                               r_fwd_cur;
    logic                               r_fwd_nxt;
    fnas_pkg::t_row_wd                  r_fwd_data;

    assign nxt_addr = (i_rd_addr == LAST_ADDR) ? i_rd_addr : i_rd_addr + AW'(1);
    assign fwd_cur  = i_wr_en && (i_wr_addr == i_rd_addr);
    assign fwd_nxt  = i_wr_en && (i_wr_addr == nxt_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_prev[i_wr_addr]  <= i_wr_data.prev;
            r_mem_pprev[i_wr_addr] <= i_wr_data.pprev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_raw_prev_cur  <= r_mem_prev[i_rd_addr];
            r_raw_prev_nxt  <= r_mem_prev[nxt_addr];
            r_raw_pprev_cur <= r_mem_pprev[i_rd_addr];
            r_fwd_cur       <= fwd_cur;
            r_fwd_nxt       <= fwd_nxt;
            r_fwd_data      <= i_wr_data;
        end
    end

    always_comb begin
        o_rd_data.prev_cur  = r_fwd_cur ? r_fwd_data.prev  : r_raw_prev_cur;
        o_rd_data.prev_nxt  = r_fwd_nxt ? r_fwd_data.prev  : r_raw_prev_nxt;
        o_rd_data.pprev_cur = r_fwd_cur ? r_fwd_data.pprev : r_raw_pprev_cur;
    end

endmodule

@@ rtl/fnas_out_fifo.sv @@
// Result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module fnas_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push_a,
    input  fnas_pkg::t_res                   i_res_a,
    input  logic                             i_push_b,
    input  fnas_pkg::t_res                   i_res_b,
    input  logic                             i_pop,
    output fnas_pkg::t_res                   o_head,
    output logic [fnas_pkg::OUT_CNT_W-1:0]   o_count
);

    fnas_pkg::t_res r_mem [fnas_pkg::OUT_DEPTH];

    logic [fnas_pkg::OUT_PTR_W-1:0] r_wptr;
    logic [fnas_pkg::OUT_PTR_W-1:0] r_rptr;
    logic [fnas_pkg::OUT_CNT_W-1:0] r_count;
    logic [fnas_pkg::OUT_PTR_W-1:0] b_addr;
    logic [fnas_pkg::OUT_PTR_W-1:0] n_wptr;
    logic [fnas_pkg::OUT_CNT_W-1:0] n_count;

    always_comb begin
        b_addr  = i_push_a ? r_wptr + fnas_pkg::OUT_PTR_W'(1) : r_wptr;
        n_wptr  = r_wptr + fnas_pkg::OUT_PTR_W'(i_push_a) + fnas_pkg::OUT_PTR_W'(i_push_b);
        n_count = r_count + fnas_pkg::OUT_CNT_W'(i_push_a) + fnas_pkg::OUT_CNT_W'(i_push_b)
                  - fnas_pkg::OUT_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_res_a;
        end
        if (i_push_b) begin
            r_mem[b_addr] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (i_pop) begin
                r_rptr <= r_rptr + fnas_pkg::OUT_PTR_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

@@ rtl/fnas_checker.sv @@
// Port-level checks of the stencil block and their attachment to the top level.
`timescale 1ns / 1ps

module fnas_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [15:0]                  m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [fnas_pkg::PADDR_W-1:0] paddr,
    input logic [fnas_pkg::APB_DW-1:0]  pwdata,
    input logic [fnas_pkg::APB_DW-1:0]  prdata
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A written size reads back on the next cycle.
    a_size_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |->
            prdata == {21'b0, $past(pwdata[10:0])})
        else $error("matrix size read back wrong");

    // A result only appears after an input beat that has passed the stage B registers and the result queue.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without an input beat");

endmodule

bind four_neighbour_average_stencil fnas_checker u_fnas_checker (.*);
